[hw/rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes for the positional list engine
// Beat layouts, command and status codes, and the control and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Field widths fixed by the beat layouts.
  localparam int CMD_W = 4;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  // Command codes carried in the command field.
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_END   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_END   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_WALK      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd8;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  // Input beat.
  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        position_out;
    logic                    last;
  } out_item_t;

  // Scan pointer update.
  typedef enum logic [2:0] {
    SRC_HOLD,
    SRC_ZERO,
    SRC_CNT_M1,
    SRC_NEWTGT,
    SRC_INC,
    SRC_DEC
  } src_op_t;

  // Target index source.
  typedef enum logic [1:0] {
    TGT_ZERO,
    TGT_POS,
    TGT_CNT,
    TGT_CNT_M1
  } tgt_sel_t;

  // Memory write source.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_VALUE
  } wr_op_t;

  // Entry count update.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  // Result value source.
  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_IN,
    VAL_RD,
    VAL_REM
  } val_sel_t;

  // Result position source.
  typedef enum logic [1:0] {
    POS_ZERO,
    POS_TGT,
    POS_PIPE
  } pos_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            latch_in;
    logic            tgt_ld;
    tgt_sel_t        tgt_sel;
    src_op_t         src_op;
    logic            rd_en;
    wr_op_t          wr_op;
    cnt_op_t         cnt_op;
    logic            rem_ld;
    logic            out_ld;
    logic [ST_W-1:0] out_status;
    val_sel_t        out_val;
    pos_sel_t        out_pos;
    logic            out_last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             full;
    logic             empty;
    logic             ins_pos_ok;
    logic             del_pos_ok;
    logic             tgt_at_cnt;
    logic             src_at_tgt;
    logic             src_at_last;
    logic             pipe_at_last;
    logic             match;
    logic             out_free;
  } dp_stat_t;

endpackage

[hw/rtl/positional_list_engine_core.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_core: bounded ordered list of signed 32-bit values
// Holds up to CAPACITY entries in position order. Each input beat carries one
// command: insert at front, position or end; delete at front, position or
// end; walk; search; clear.
// Input channel in_*: one command per beat, taken when in_valid is high and
// in_stall is low. in_stall is high from acceptance until the command's last
// result beat has been loaded into the output register.
// Output channel out_*: one beat per command, or one per entry for a walk;
// the final beat of a command has last set. Undefined commands give no beat.
// While an insert, delete or search runs, the entry memory moves or reads one
// entry per cycle. A walk reads each entry, then loads its beat once the
// output register is free. Clear and rejected commands go straight to the
// result beat.
// Reset empties the list and the output register, not the entry contents.
// While out_stall is high the output beat holds and the engine waits to load
// the next one; the next command is taken once the last beat is loaded.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ple_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ple_pkg::out_item_t out_data
);

  ple_pkg::ctl_cmd_t cmd;
  ple_pkg::dp_stat_t stat;

  // Command sequencer.
  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Entry memory, pointers and output register.
  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/ple_datapath.sv]
// ----------------------------------------------------------------------------
// ple_datapath: entry memory, pointers and result register
// Holds the list in a memory with one write port and a registered read port,
// the entry count, the scan and target pointers and the output beat register.
// ----------------------------------------------------------------------------
module ple_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ple_pkg::ctl_cmd_t   cmd,
  output ple_pkg::dp_stat_t   stat,
  input  ple_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ple_pkg::out_item_t  out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ple_pkg::POS_W + 1;

  // Entry storage and its registered read port.
  logic [ple_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [ple_pkg::VAL_W-1:0] rd_data_r;
  logic [AW-1:0]             pipe_r;

  // Latched item and working registers.
  logic [ple_pkg::CMD_W-1:0] cmd_code_r;
  logic [ple_pkg::POS_W-1:0] pos_r;
  logic [ple_pkg::VAL_W-1:0] val_r;
  logic [ple_pkg::VAL_W-1:0] rem_r;
  logic [AW-1:0]             tgt_r;
  logic [AW-1:0]             tgt_nxt;
  logic [AW-1:0]             src_r;
  logic [AW-1:0]             src_nxt;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             cnt_nxt;
  logic [CW-1:0]             cnt_m1;

  // Output beat register.
  logic                      out_valid_r;
  ple_pkg::out_item_t        out_data_r;
  ple_pkg::out_item_t        out_data_nxt;

  // Write port.
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [ple_pkg::VAL_W-1:0] wr_data;

  assign cnt_m1 = cnt_r - CW'(1);

  // Target index selection.
  always_comb begin
    unique case (cmd.tgt_sel)
      ple_pkg::TGT_ZERO:   tgt_nxt = '0;
      ple_pkg::TGT_POS:    tgt_nxt = AW'(pos_r - ple_pkg::POS_W'(1));
      ple_pkg::TGT_CNT:    tgt_nxt = AW'(cnt_r);
      ple_pkg::TGT_CNT_M1: tgt_nxt = AW'(cnt_m1);
      default:             tgt_nxt = '0;
    endcase
  end

  // Scan pointer update.
  always_comb begin
    unique case (cmd.src_op)
      ple_pkg::SRC_ZERO:   src_nxt = '0;
      ple_pkg::SRC_CNT_M1: src_nxt = AW'(cnt_m1);
      ple_pkg::SRC_NEWTGT: src_nxt = tgt_nxt;
      ple_pkg::SRC_INC:    src_nxt = src_r + AW'(1);
      ple_pkg::SRC_DEC:    src_nxt = src_r - AW'(1);
      default:             src_nxt = src_r;
    endcase
  end

  // Entry count update.
  always_comb begin
    unique case (cmd.cnt_op)
      ple_pkg::CNT_INC: cnt_nxt = cnt_r + CW'(1);
      ple_pkg::CNT_DEC: cnt_nxt = cnt_m1;
      ple_pkg::CNT_CLR: cnt_nxt = '0;
      default:          cnt_nxt = cnt_r;
    endcase
  end

  // Write address and data: shift moves copy the word read last cycle.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = tgt_r;
    wr_data = val_r;
    unique case (cmd.wr_op)
      ple_pkg::WR_UP: begin
        wr_addr = pipe_r + AW'(1);
        wr_data = rd_data_r;
      end
      ple_pkg::WR_DOWN: begin
        wr_addr = pipe_r - AW'(1);
        wr_data = rd_data_r;
      end
      ple_pkg::WR_VALUE: begin
        wr_addr = tgt_r;
        wr_data = val_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[src_r];
      pipe_r    <= src_r;
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_code_r <= in_data.command;
      pos_r      <= in_data.position;
      val_r      <= in_data.value;
    end
    if (cmd.tgt_ld) begin
      tgt_r <= tgt_nxt;
    end
    if (cmd.rem_ld) begin
      rem_r <= rd_data_r;
    end
    src_r <= src_nxt;
    if (cmd.out_ld) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Result beat assembly.
  always_comb begin
    out_data_nxt.status = cmd.out_status;
    out_data_nxt.last   = cmd.out_last;
    unique case (cmd.out_val)
      ple_pkg::VAL_IN:  out_data_nxt.value_out = val_r;
      ple_pkg::VAL_RD:  out_data_nxt.value_out = rd_data_r;
      ple_pkg::VAL_REM: out_data_nxt.value_out = rem_r;
      default:          out_data_nxt.value_out = '0;
    endcase
    unique case (cmd.out_pos)
      ple_pkg::POS_TGT:
        out_data_nxt.position_out = ple_pkg::POS_W'(tgt_r) + ple_pkg::POS_W'(1);
      ple_pkg::POS_PIPE:
        out_data_nxt.position_out = ple_pkg::POS_W'(pipe_r) + ple_pkg::POS_W'(1);
      default:
        out_data_nxt.position_out = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.command      = cmd_code_r;
    stat.full         = (cnt_r >= CW'(CAPACITY));
    stat.empty        = (cnt_r == '0);
    stat.ins_pos_ok   = (pos_r != '0) && (EW'(pos_r) <= EW'(cnt_r) + EW'(1));
    stat.del_pos_ok   = (pos_r != '0) && (EW'(pos_r) <= EW'(cnt_r));
    stat.tgt_at_cnt   = (CW'(tgt_r) == cnt_r);
    stat.src_at_tgt   = (src_r == tgt_r);
    stat.src_at_last  = (CW'(src_r) == cnt_m1);
    stat.pipe_at_last = (CW'(pipe_r) == cnt_m1);
    stat.match        = (rd_data_r == val_r);
    stat.out_free     = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl: command sequencer for the positional list engine
// Decodes the latched command and steps the datapath through shifts,
// scans and walks, then hands the result beat to the output register.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ple_pkg::dp_stat_t stat,
  output ple_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_START,
    S_SHUP_FIRST,
    S_SHUP,
    S_SHUP_LAST,
    S_PUT,
    S_DEL_FIRST,
    S_DEL_SECOND,
    S_DEL_MOVE,
    S_DEL_DRAIN,
    S_DEL_TAKE,
    S_WALK_RD,
    S_WALK_OUT,
    S_SEARCH,
    S_RESULT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ple_pkg::ST_W-1:0]   res_st_r, res_st_nxt;
  ple_pkg::val_sel_t          res_val_r, res_val_nxt;
  ple_pkg::pos_sel_t          res_pos_r, res_pos_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state, pending result and datapath commands.
  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    res_pos_nxt = res_pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.command) inside
          ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_POS, ple_pkg::CMD_INS_END: begin
            res_val_nxt = ple_pkg::VAL_IN;
            res_pos_nxt = ple_pkg::POS_ZERO;
            if (stat.full) begin
              res_st_nxt = ple_pkg::ST_FULL;
              state_nxt  = S_RESULT;
            end else if (stat.command == ple_pkg::CMD_INS_POS && !stat.empty
                         && !stat.ins_pos_ok) begin
              res_st_nxt = ple_pkg::ST_NOTFOUND;
              state_nxt  = S_RESULT;
            end else begin
              cmd.tgt_ld = 1'b1;
              if (stat.command == ple_pkg::CMD_INS_END) begin
                cmd.tgt_sel = ple_pkg::TGT_CNT;
              end else if (stat.command == ple_pkg::CMD_INS_POS && !stat.empty) begin
                cmd.tgt_sel = ple_pkg::TGT_POS;
              end else begin
                cmd.tgt_sel = ple_pkg::TGT_ZERO;
              end
              state_nxt = S_INS_START;
            end
          end
          ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_POS, ple_pkg::CMD_DEL_END: begin
            res_val_nxt = ple_pkg::VAL_ZERO;
            res_pos_nxt = ple_pkg::POS_ZERO;
            if (stat.empty) begin
              res_st_nxt = ple_pkg::ST_EMPTY;
              state_nxt  = S_RESULT;
            end else if (stat.command == ple_pkg::CMD_DEL_POS && !stat.del_pos_ok) begin
              res_st_nxt = ple_pkg::ST_NOTFOUND;
              state_nxt  = S_RESULT;
            end else begin
              cmd.tgt_ld = 1'b1;
              cmd.src_op = ple_pkg::SRC_NEWTGT;
              if (stat.command == ple_pkg::CMD_DEL_POS) begin
                cmd.tgt_sel = ple_pkg::TGT_POS;
              end else if (stat.command == ple_pkg::CMD_DEL_END) begin
                cmd.tgt_sel = ple_pkg::TGT_CNT_M1;
              end else begin
                cmd.tgt_sel = ple_pkg::TGT_ZERO;
              end
              state_nxt = S_DEL_FIRST;
            end
          end
          ple_pkg::CMD_WALK: begin
            if (stat.empty) begin
              res_st_nxt  = ple_pkg::ST_EMPTY;
              res_val_nxt = ple_pkg::VAL_ZERO;
              res_pos_nxt = ple_pkg::POS_ZERO;
              state_nxt   = S_RESULT;
            end else begin
              cmd.src_op = ple_pkg::SRC_ZERO;
              state_nxt  = S_WALK_RD;
            end
          end
          ple_pkg::CMD_SEARCH: begin
            res_val_nxt = ple_pkg::VAL_IN;
            res_pos_nxt = ple_pkg::POS_ZERO;
            if (stat.empty) begin
              res_st_nxt = ple_pkg::ST_EMPTY;
              state_nxt  = S_RESULT;
            end else begin
              cmd.src_op = ple_pkg::SRC_ZERO;
              state_nxt  = S_SEARCH;
            end
          end
          ple_pkg::CMD_CLEAR: begin
            cmd.cnt_op  = ple_pkg::CNT_CLR;
            res_st_nxt  = ple_pkg::ST_OK;
            res_val_nxt = ple_pkg::VAL_ZERO;
            res_pos_nxt = ple_pkg::POS_ZERO;
            state_nxt   = S_RESULT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // Insert: shift entries from the tail down to the target up by one.
      S_INS_START: begin
        if (stat.tgt_at_cnt) begin
          state_nxt = S_PUT;
        end else begin
          cmd.src_op = ple_pkg::SRC_CNT_M1;
          state_nxt  = S_SHUP_FIRST;
        end
      end
      S_SHUP_FIRST, S_SHUP: begin
        cmd.rd_en = 1'b1;
        if (state_r == S_SHUP) begin
          cmd.wr_op = ple_pkg::WR_UP;
        end
        if (stat.src_at_tgt) begin
          state_nxt = S_SHUP_LAST;
        end else begin
          cmd.src_op = ple_pkg::SRC_DEC;
          state_nxt  = S_SHUP;
        end
      end
      S_SHUP_LAST: begin
        cmd.wr_op = ple_pkg::WR_UP;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        cmd.wr_op   = ple_pkg::WR_VALUE;
        cmd.cnt_op  = ple_pkg::CNT_INC;
        res_st_nxt  = ple_pkg::ST_OK;
        res_val_nxt = ple_pkg::VAL_IN;
        res_pos_nxt = ple_pkg::POS_TGT;
        state_nxt   = S_RESULT;
      end
      // Delete: read the target, then move later entries down by one.
      S_DEL_FIRST: begin
        cmd.rd_en = 1'b1;
        if (stat.src_at_last) begin
          state_nxt = S_DEL_TAKE;
        end else begin
          cmd.src_op = ple_pkg::SRC_INC;
          state_nxt  = S_DEL_SECOND;
        end
      end
      S_DEL_SECOND, S_DEL_MOVE: begin
        cmd.rd_en = 1'b1;
        if (state_r == S_DEL_SECOND) begin
          cmd.rem_ld = 1'b1;
        end else begin
          cmd.wr_op = ple_pkg::WR_DOWN;
        end
        if (stat.src_at_last) begin
          state_nxt = S_DEL_DRAIN;
        end else begin
          cmd.src_op = ple_pkg::SRC_INC;
          state_nxt  = S_DEL_MOVE;
        end
      end
      S_DEL_DRAIN, S_DEL_TAKE: begin
        if (state_r == S_DEL_DRAIN) begin
          cmd.wr_op = ple_pkg::WR_DOWN;
        end else begin
          cmd.rem_ld = 1'b1;
        end
        cmd.cnt_op  = ple_pkg::CNT_DEC;
        res_st_nxt  = ple_pkg::ST_OK;
        res_val_nxt = ple_pkg::VAL_REM;
        res_pos_nxt = ple_pkg::POS_TGT;
        state_nxt   = S_RESULT;
      end
      // Walk: one read and one beat per entry.
      S_WALK_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WALK_OUT;
      end
      S_WALK_OUT: begin
        if (stat.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = ple_pkg::ST_OK;
          cmd.out_val    = ple_pkg::VAL_RD;
          cmd.out_pos    = ple_pkg::POS_PIPE;
          cmd.out_last   = stat.pipe_at_last;
          if (stat.pipe_at_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.src_op = ple_pkg::SRC_INC;
            state_nxt  = S_WALK_RD;
          end
        end
      end
      // Search: issue reads in order, compare each word in the cycle after its read.
      S_SEARCH: begin
        if (cmd.src_op == ple_pkg::SRC_HOLD && res_pos_r == ple_pkg::POS_PIPE
            && stat.match) begin
          res_st_nxt = ple_pkg::ST_OK;
          state_nxt  = S_RESULT;
        end else if (res_pos_r == ple_pkg::POS_PIPE && stat.match) begin
          res_st_nxt = ple_pkg::ST_OK;
          state_nxt  = S_RESULT;
        end else if (res_pos_r == ple_pkg::POS_PIPE && stat.pipe_at_last) begin
          res_st_nxt  = ple_pkg::ST_NOTFOUND;
          res_pos_nxt = ple_pkg::POS_ZERO;
          state_nxt   = S_RESULT;
        end else begin
          cmd.rd_en   = 1'b1;
          res_pos_nxt = ple_pkg::POS_PIPE;
          if (!stat.src_at_last) begin
            cmd.src_op = ple_pkg::SRC_INC;
          end
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = res_st_r;
          cmd.out_val    = res_val_r;
          cmd.out_pos    = res_pos_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and pending result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_st_r  <= ple_pkg::ST_OK;
      res_val_r <= ple_pkg::VAL_ZERO;
      res_pos_r <= ple_pkg::POS_ZERO;
    end else begin
      state_r   <= state_nxt;
      res_st_r  <= res_st_nxt;
      res_val_r <= res_val_nxt;
      res_pos_r <= res_pos_nxt;
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional list engine
// A queue-fed driver sends command beats to the engine, and a clocked monitor
// checks every result beat against a shadow list kept in the bench. Directed
// corner cases come first. Random fill, drain and mixed sequences follow,
// under several idle and stall mixes and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAPACITY         = 16;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES     = 40;
  localparam int PHASE_OPS        = 72;
  localparam int PRESSURE_OPS     = 30;
  localparam int MAX_PRINTED      = 40;

  // Random sequence flavors.
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ple_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ple_pkg::out_item_t out_data;

  // Command beats waiting to be sent, and result beats still owed.
  ple_pkg::in_item_t  cmd_queue[$];
  ple_pkg::out_item_t expected_beats[$];

  // Shadow copy of the list contents.
  logic signed [ple_pkg::VAL_W-1:0] shadow_vals [CAPACITY];
  int shadow_len = 0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  long_hold_req  = 1'b0;
  int  hold_left      = 0;
  bit  in_fire        = 1'b0;
  int  cycle_count    = 0;
  int  error_count    = 0;
  int  cmds_taken     = 0;
  int  beats_checked  = 0;
  int  walks_taken    = 0;
  int  full_rejects   = 0;
  ple_pkg::out_item_t want;

  positional_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  // Apply one command to the shadow list and queue the beats it owes.
  task automatic apply_list_command(input ple_pkg::in_item_t cmd_item);
    ple_pkg::out_item_t beat;
    int idx;
    int i;
    bit hit;
    beat = '0;
    beat.last = 1'b1;
    beat.value_out = cmd_item.value;
    idx = -1;
    hit = 1'b0;
    cmds_taken++;
    case (cmd_item.command)
      ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_POS, ple_pkg::CMD_INS_END: begin
        // The full check wins over the position check.
        if (shadow_len >= CAPACITY) begin
          beat.status = ple_pkg::ST_FULL;
          full_rejects++;
        end else if (cmd_item.command == ple_pkg::CMD_INS_FRONT || shadow_len == 0) begin
          idx = 0;
        end else if (cmd_item.command == ple_pkg::CMD_INS_END) begin
          idx = shadow_len;
        end else if (cmd_item.position >= 1 && cmd_item.position <= shadow_len + 1) begin
          idx = cmd_item.position - 1;
        end else begin
          beat.status = ple_pkg::ST_NOTFOUND;
        end
        if (idx >= 0) begin
          for (i = shadow_len; i > idx; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[idx] = cmd_item.value;
          shadow_len++;
          beat.status = ple_pkg::ST_OK;
          beat.position_out = ple_pkg::POS_W'(idx + 1);
        end
        expected_beats.push_back(beat);
      end
      ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_POS, ple_pkg::CMD_DEL_END: begin
        beat.value_out = '0;
        if (shadow_len == 0) begin
          beat.status = ple_pkg::ST_EMPTY;
        end else if (cmd_item.command == ple_pkg::CMD_DEL_FRONT) begin
          idx = 0;
        end else if (cmd_item.command == ple_pkg::CMD_DEL_END) begin
          idx = shadow_len - 1;
        end else if (cmd_item.position >= 1 && cmd_item.position <= shadow_len) begin
          idx = cmd_item.position - 1;
        end else begin
          beat.status = ple_pkg::ST_NOTFOUND;
        end
        if (idx >= 0) begin
          beat.status = ple_pkg::ST_OK;
          beat.value_out = shadow_vals[idx];
          beat.position_out = ple_pkg::POS_W'(idx + 1);
          for (i = idx; i < shadow_len - 1; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_len--;
        end
        expected_beats.push_back(beat);
      end
      ple_pkg::CMD_WALK: begin
        walks_taken++;
        if (shadow_len == 0) begin
          beat.status = ple_pkg::ST_EMPTY;
          beat.value_out = '0;
          expected_beats.push_back(beat);
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            beat.status = ple_pkg::ST_OK;
            beat.value_out = shadow_vals[i];
            beat.position_out = ple_pkg::POS_W'(i + 1);
            beat.last = (i == shadow_len - 1);
            expected_beats.push_back(beat);
          end
        end
      end
      ple_pkg::CMD_SEARCH: begin
        // The first matching entry is the one reported.
        if (shadow_len == 0) begin
          beat.status = ple_pkg::ST_EMPTY;
        end else begin
          beat.status = ple_pkg::ST_NOTFOUND;
          for (i = 0; i < shadow_len && !hit; i++) begin
            if (shadow_vals[i] == cmd_item.value) begin
              hit = 1'b1;
              beat.status = ple_pkg::ST_OK;
              beat.position_out = ple_pkg::POS_W'(i + 1);
            end
          end
        end
        expected_beats.push_back(beat);
      end
      ple_pkg::CMD_CLEAR: begin
        shadow_len = 0;
        beat.status = ple_pkg::ST_OK;
        beat.value_out = '0;
        expected_beats.push_back(beat);
      end
      default: begin
        // Undefined commands change nothing and owe no beat.
      end
    endcase
  endtask

  task automatic queue_op(input logic [ple_pkg::CMD_W-1:0] cmd, input int pos,
                          input logic [ple_pkg::VAL_W-1:0] val);
    ple_pkg::in_item_t cmd_item;
    cmd_item.command = cmd;
    cmd_item.position = ple_pkg::POS_W'(pos);
    cmd_item.value = val;
    cmd_queue.push_back(cmd_item);
  endtask

  // Queue random commands in runs that grow, shrink or churn the list.
  task automatic queue_random_ops(input int n_ops);
    ple_pkg::in_item_t cmd_item;
    int done_ops;
    int left_in_mode;
    int mode;
    int pick;
    done_ops = 0;
    left_in_mode = 0;
    mode = MODE_MIXED;
    while (done_ops < n_ops) begin
      if (left_in_mode == 0) begin
        mode = $urandom_range(MODE_FILL, MODE_MIXED);
        left_in_mode = $urandom_range(8, 24);
      end
      // Positions cluster around the list size; values often repeat.
      if ($urandom_range(0, 9) == 0) begin
        cmd_item.position = ple_pkg::POS_W'($urandom_range(0, 127));
      end else begin
        cmd_item.position = ple_pkg::POS_W'($urandom_range(0, CAPACITY + 2));
      end
      if ($urandom_range(0, 1) == 0) begin
        cmd_item.value = $urandom;
      end else begin
        cmd_item.value = $urandom_range(0, 7) - 4;
      end
      pick = $urandom_range(0, 99);
      case (mode)
        MODE_FILL: begin
          if (pick < 25)      cmd_item.command = ple_pkg::CMD_INS_FRONT;
          else if (pick < 50) cmd_item.command = ple_pkg::CMD_INS_POS;
          else if (pick < 70) cmd_item.command = ple_pkg::CMD_INS_END;
          else if (pick < 78) cmd_item.command = ple_pkg::CMD_SEARCH;
          else if (pick < 86) cmd_item.command = ple_pkg::CMD_WALK;
          else if (pick < 90) cmd_item.command = ple_pkg::CMD_DEL_FRONT;
          else if (pick < 95) cmd_item.command = ple_pkg::CMD_DEL_POS;
          else                cmd_item.command = ple_pkg::CMD_DEL_END;
        end
        MODE_DRAIN: begin
          if (pick < 20)      cmd_item.command = ple_pkg::CMD_DEL_FRONT;
          else if (pick < 45) cmd_item.command = ple_pkg::CMD_DEL_POS;
          else if (pick < 65) cmd_item.command = ple_pkg::CMD_DEL_END;
          else if (pick < 75) cmd_item.command = ple_pkg::CMD_WALK;
          else if (pick < 85) cmd_item.command = ple_pkg::CMD_SEARCH;
          else if (pick < 90) cmd_item.command = ple_pkg::CMD_INS_FRONT;
          else if (pick < 95) cmd_item.command = ple_pkg::CMD_INS_POS;
          else                cmd_item.command = ple_pkg::CMD_INS_END;
        end
        default: begin
          if (pick < 4) cmd_item.command = ple_pkg::CMD_CLEAR;
          else cmd_item.command = ple_pkg::CMD_W'($urandom_range(ple_pkg::CMD_INS_FRONT,
                                                                 ple_pkg::CMD_SEARCH));
        end
      endcase
      // A few undefined commands as noise; they do not count as work.
      if ($urandom_range(0, 99) < 4) begin
        cmd_item.command = ple_pkg::CMD_W'($urandom_range(ple_pkg::CMD_CLEAR + 1,
                                                          (1 << ple_pkg::CMD_W) - 1));
      end else begin
        done_ops++;
        left_in_mode--;
      end
      cmd_queue.push_back(cmd_item);
    end
  endtask

  // Wait until every queued beat is sent and every owed beat has arrived.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_queue.size() != 0 || in_valid || expected_beats.size() != 0);
  endtask

  // Driver: a new beat goes out only after the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (cmd_queue.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= cmd_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with a counted long hold on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // Monitor: predict on each command beat taken, check each result beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) apply_list_command(in_data);
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed: %p", out_data));
        end else begin
          want = expected_beats.pop_front();
          beats_checked++;
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.value_out !== want.value_out)
            report_mismatch($sformatf("value_out got %0d want %0d",
                                      out_data.value_out, want.value_out));
          if (out_data.position_out !== want.position_out)
            report_mismatch($sformatf("position_out got %0d want %0d",
                                      out_data.position_out, want.position_out));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d",
                                      out_data.last, want.last));
        end
      end
    end
  end

  // Cycle count and run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d beats owed.",
               CYCLE_LIMIT, expected_beats.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corner cases, starting from an empty list.
    queue_op(ple_pkg::CMD_DEL_FRONT, 0, 0);
    queue_op(ple_pkg::CMD_DEL_POS, 1, 0);
    queue_op(ple_pkg::CMD_DEL_END, 0, 0);
    queue_op(ple_pkg::CMD_WALK, 0, 0);
    queue_op(ple_pkg::CMD_SEARCH, 0, 5);
    queue_op(ple_pkg::CMD_INS_POS, 127, 32'h7fff_ffff);
    queue_op(ple_pkg::CMD_INS_FRONT, 0, 32'h8000_0000);
    queue_op(ple_pkg::CMD_INS_END, 0, 32'hffff_ffff);
    queue_op(ple_pkg::CMD_INS_POS, 0, 11);
    queue_op(ple_pkg::CMD_INS_POS, 5, 12);
    queue_op(ple_pkg::CMD_INS_POS, 4, 13);
    queue_op(ple_pkg::CMD_INS_POS, 1, 0);
    queue_op(ple_pkg::CMD_WALK, 0, 0);
    queue_op(ple_pkg::CMD_INS_END, 0, 32'hffff_ffff);
    queue_op(ple_pkg::CMD_SEARCH, 0, 32'hffff_ffff);
    queue_op(ple_pkg::CMD_SEARCH, 0, 12345);
    queue_op(ple_pkg::CMD_DEL_POS, 0, 0);
    queue_op(ple_pkg::CMD_DEL_POS, 7, 0);
    queue_op(ple_pkg::CMD_DEL_POS, 6, 0);
    queue_op(ple_pkg::CMD_DEL_POS, 1, 0);
    queue_op(ple_pkg::CMD_DEL_END, 0, 0);
    queue_op(ple_pkg::CMD_DEL_FRONT, 0, 0);
    queue_op({ple_pkg::CMD_W{1'b1}}, 127, 32'hffff_ffff);
    queue_op(ple_pkg::CMD_WALK, 0, 0);
    queue_op(ple_pkg::CMD_CLEAR, 0, 0);
    queue_op(ple_pkg::CMD_WALK, 0, 0);
    wait_idle();

    // Random sequences under each idle and stall mix.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_ops(PHASE_OPS);
    wait_idle();

    send_idle_pct = 68;
    recv_stall_pct = 0;
    queue_random_ops(PHASE_OPS);
    wait_idle();

    send_idle_pct = 0;
    recv_stall_pct = 68;
    queue_random_ops(PHASE_OPS);
    wait_idle();

    send_idle_pct = 23;
    recv_stall_pct = 23;
    queue_random_ops(PHASE_OPS);
    wait_idle();

    // Long output hold while the sender keeps offering beats.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b1;
    queue_random_ops(PRESSURE_OPS);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));

    $display("Covered %0d commands, %0d walks and %0d full-list rejects under four",
             cmds_taken, walks_taken, full_rejects);
    $display("idle mixes plus a long output hold; %0d result beats checked, %0d errors.",
             beats_checked, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
